// ===== sv/wpid_pkg.sv =====
// ----------------------------------------------------------------------------
// wpid_pkg: shared types and constants for the windowed PID speed controller
// Holds payload structs, the configuration register set, register indexes and
// the fixed-point widths used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package wpid_pkg;

  // Default window depth and its supported range upper bound
  localparam int WINDOW_DEF = 10;
  localparam int WINDOW_MAX = 64;

  // Error sum width covers WINDOW_MAX errors of +/-32767
  localparam int SUM_W = 22;

  // Work queue between front end and back end
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP  = 2'd0,
    CFG_GAIN_INTEG = 2'd1,
    CFG_GAIN_DERIV = 2'd2,
    CFG_STEP_TIME  = 2'd3
  } cfg_idx_t;

  localparam logic signed [15:0] GAIN_PROP_RST  = 16'sd4096;
  localparam logic signed [15:0] GAIN_INTEG_RST = 16'sd0;
  localparam logic signed [15:0] GAIN_DERIV_RST = 16'sd0;
  localparam logic        [15:0] STEP_TIME_RST  = 16'd3277;

  // Output saturation, Q1.14 and at the 2^-30 working scale
  localparam logic signed [15:0] DRIVE_MAX = 16'sd16384;
  localparam logic signed [15:0] DRIVE_MIN = -16'sd16384;
  localparam logic signed [63:0] RAW_LIM   = 64'sd1073741824;

  typedef struct packed {
    logic [14:0] target_speed;
    logic [14:0] measured_speed;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic        [15:0] step_time;
  } cfg_t;

  // One classified item: error, error delta, window sum, history flag
  typedef struct packed {
    logic signed [15:0]      err;
    logic signed [16:0]      derr;
    logic signed [SUM_W-1:0] sum;
    logic                    hist;
  } qent_t;

endpackage

// ===== sv/windowed_pid_speed_control.sv =====
// ----------------------------------------------------------------------------
// windowed_pid_speed_control: longitudinal PID speed loop with windowed I term
// Turns a target/measured speed pair into a saturated Q1.14 drive value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): one item per control step,
//   target and measured speed in 1/64 km/h. An item is taken when in_valid
//   is high and in_stall is low.
//   Result channel (out_valid/out_stall/out_data): one item per input item,
//   drive in Q1.14 saturated to [-1.0, +1.0] plus a clamp flag.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): gains and step
//   time, always ready; write only while no item is in flight.
//   The back end takes a new item only after it has loaded the last
//   result into its output register; its derivative term runs a 60-step
//   bit-serial divide by the step time. The front end takes a new item
//   once it has pushed the last one, until the 2-entry queue fills,
//   so a short burst is absorbed while the back end works.
//   Stall: a stalled result holds in the output register; the back end
//   waits there, the queue fills and in_stall rises.
//   Reset (rst_n low, synchronous): empties the error window, the queue and
//   the output register, and loads the default gains and step time.
// ----------------------------------------------------------------------------
module windowed_pid_speed_control
  import wpid_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_in, q_out;

  // Configuration registers: always ready, one write per cycle
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:  cfg_nxt.gain_prop  = $signed(cfg_data);
        CFG_GAIN_INTEG: cfg_nxt.gain_integ = $signed(cfg_data);
        CFG_GAIN_DERIV: cfg_nxt.gain_deriv = $signed(cfg_data);
        CFG_STEP_TIME:  cfg_nxt.step_time  = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop  <= GAIN_PROP_RST;
      cfg_r.gain_integ <= GAIN_INTEG_RST;
      cfg_r.gain_deriv <= GAIN_DERIV_RST;
      cfg_r.step_time  <= STEP_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: error, window, running sum
  wpid_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Decouple the front end from the slow arithmetic
  wpid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: multiplies, divide, saturation, output register
  wpid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted item reaches the queue on the next cycle
  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_push)
    else $error("accepted item not pushed to queue");

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop))
    else $error("queue overflow");

  // A shown result stays within the saturation range
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive <= DRIVE_MAX && out_data.drive >= DRIVE_MIN))
    else $error("drive out of range");

  // A clamped result sits exactly at one rail
  a_clamp_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clamped) |->
      (out_data.drive == DRIVE_MAX || out_data.drive == DRIVE_MIN))
    else $error("clamp flag without rail value");
`endif

endmodule

// ===== sv/wpid_front.sv =====
// ----------------------------------------------------------------------------
// wpid_front: input front end
// Accepts an item, forms the speed error, maintains the error window memory,
// its fill count and running sum, and hands a classified entry to the queue.
// ----------------------------------------------------------------------------
module wpid_front
  import wpid_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  logic  q_full,
  output logic  q_push,
  output qent_t q_data
);

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    FS_IDLE = 2'b01,
    FS_UPD  = 2'b10
  } fstate_t;

  fstate_t                 state_r, state_nxt;
  logic signed [15:0]      err_r, err_nxt;
  logic signed [15:0]      last_r, last_nxt;
  logic signed [15:0]      rd_r;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    accept;
  logic                    full;
  logic signed [15:0]      win_mem [WINDOW];

  assign in_stall = (state_r != FS_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill_r == FILL_W'(WINDOW));
  assign q_push   = (state_r == FS_UPD);

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    case (state_r)
      FS_IDLE: begin
        if (accept) begin
          err_nxt   = $signed({1'b0, in_data.target_speed})
                    - $signed({1'b0, in_data.measured_speed});
          state_nxt = FS_UPD;
        end
      end
      FS_UPD: begin
        // drop the oldest error from the sum once the window is full
        sum_nxt  = sum_r - (full ? SUM_W'(rd_r) : '0) + SUM_W'(err_r);
        ptr_nxt  = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        fill_nxt = full ? fill_r : fill_r + 1'b1;
        last_nxt = err_r;
        state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    q_data.err  = err_r;
    q_data.derr = 17'(err_r) - 17'(last_r);
    q_data.sum  = sum_nxt;
    q_data.hist = full || (fill_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      ptr_r   <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
  end

  // Window memory: one write, one registered read at the ring pointer
  always_ff @(posedge clk) begin
    if (state_r == FS_UPD) begin
      win_mem[ptr_r] <= err_r;
    end
    rd_r <= win_mem[ptr_r];
  end

endmodule

// ===== sv/wpid_queue.sv =====
// ----------------------------------------------------------------------------
// wpid_queue: short work queue
// Buffers classified entries between the front end and the back end.
// ----------------------------------------------------------------------------
module wpid_queue
  import wpid_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output qent_t pop_data,
  output logic  full,
  output logic  empty
);

  qent_t              ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/wpid_back.sv =====
// ----------------------------------------------------------------------------
// wpid_back: PID arithmetic back end
// Pops a classified entry, forms the P, I and D terms at a 2^-30 scale with
// a bit-serial divider for the derivative, saturates and registers the result.
// ----------------------------------------------------------------------------
module wpid_back
  import wpid_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  qent_t q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int MAG_W = 32;
  localparam int DIV_W = MAG_W + 28;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int KI_W  = 16 + SUM_W;
  localparam int IP_W  = KI_W + 17;

  typedef enum logic [5:0] {
    BS_IDLE = 6'b000001,
    BS_MUL1 = 6'b000010,
    BS_MUL2 = 6'b000100,
    BS_DIV  = 6'b001000,
    BS_SUM  = 6'b010000,
    BS_OUT  = 6'b100000
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  qent_t                   ent_r;
  logic signed [31:0]      p_r;
  logic signed [32:0]      kdde_r;
  logic signed [KI_W-1:0]  kisum_r;
  logic signed [IP_W-1:0]  ip_r;
  logic [DIV_W-1:0]        dvd_r, quo_r;
  logic [15:0]             rem_r, dsr_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [63:0]      raw_r, raw_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r;
  logic                    load_out;

  logic [16:0]             rem_sh;
  logic                    q_bit;
  logic [15:0]             rem_nxt;
  logic signed [32:0]      mag33;
  logic signed [63:0]      p64, i64, d64, q64;
  logic                    clamp;

  assign q_pop     = (state_r == BS_IDLE) && !q_empty;
  assign load_out  = (state_r == BS_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt = q_bit ? 16'(rem_sh - {1'b0, dsr_r}) : rem_sh[15:0];
  assign mag33   = kdde_r[32] ? -kdde_r : kdde_r;

  always_comb begin
    p64 = 64'(p_r) <<< 12;
    i64 = 64'(ip_r >>> 4);
    q64 = {{(64 - DIV_W){1'b0}}, quo_r};
    // floor for a negative numerator: -q, or -q-1 when inexact
    if (neg_r) begin
      d64 = (rem_r != '0) ? ~q64 : -q64;
    end else begin
      d64 = q64;
    end
    raw_nxt = p64 + (ent_r.hist ? (i64 + d64) : 64'sd0);
  end

  assign clamp = (raw_r > RAW_LIM) || (raw_r < -RAW_LIM);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: if (!q_empty) state_nxt = BS_MUL1;
      BS_MUL1: state_nxt = BS_MUL2;
      BS_MUL2: state_nxt = BS_DIV;
      BS_DIV:  if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = BS_SUM;
      BS_SUM:  state_nxt = BS_OUT;
      BS_OUT:  if (load_out) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (state_r == BS_MUL1) begin
      p_r     <= 32'(cfg.gain_prop) * 32'(ent_r.err);
      kdde_r  <= 33'(cfg.gain_deriv) * 33'(ent_r.derr);
      kisum_r <= KI_W'(cfg.gain_integ) * KI_W'(ent_r.sum);
    end
    if (state_r == BS_MUL2) begin
      ip_r  <= IP_W'(kisum_r) * IP_W'($signed({1'b0, cfg.step_time}));
      dvd_r <= {mag33[MAG_W-1:0], 28'd0};
      rem_r <= '0;
      dsr_r <= (cfg.step_time == '0) ? 16'd1 : cfg.step_time;
      neg_r <= kdde_r[32];
      cnt_r <= '0;
    end
    if (state_r == BS_DIV) begin
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == BS_SUM) begin
      raw_r <= raw_nxt;
    end
    if (load_out) begin
      out_data_r.clamped <= clamp;
      if (clamp) begin
        out_data_r.drive <= raw_r[63] ? DRIVE_MIN : DRIVE_MAX;
      end else begin
        out_data_r.drive <= raw_r[31:16];
      end
    end
  end

endmodule
